### rtl/i2cm_pkg.sv
package i2cm_pkg;

    // Controller phases
    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_SDA   = 5'd1,
        PH_ST_SCL   = 5'd2,
        PH_ST_LOW   = 5'd3,
        PH_ST_CLK   = 5'd4,
        PH_TX_DATA  = 5'd5,
        PH_TX_CLK   = 5'd6,
        PH_TX_WAIT  = 5'd7,
        PH_ACK_REL  = 5'd8,
        PH_ACK_CLK  = 5'd9,
        PH_ACK_WAIT = 5'd10,
        PH_RX_CLK   = 5'd11,
        PH_RX_WAIT  = 5'd12,
        PH_NK_CLK   = 5'd13,
        PH_NK_WAIT  = 5'd14,
        PH_SP_SDA   = 5'd15,
        PH_SP_SCL   = 5'd16,
        PH_SP_WAIT  = 5'd17
    } phase_t;

    // Request kind as seen by the front end
    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_kind_t;

    // Byte slots within a transaction
    localparam logic [2:0] SLOT_DEV_WR = 3'd0;
    localparam logic [2:0] SLOT_REG    = 3'd1;
    localparam logic [2:0] SLOT_THIRD  = 3'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam int         QUEUE_DEPTH   = 2;
    localparam int         QPTR_W        = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       func;
        logic       is_read;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       scl_in;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic       nack;
        logic [7:0] read_data;
    } out_item_t;

    // Classified request held in the queue
    typedef struct packed {
        cmd_kind_t  kind;
        logic       is_read;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       scl;
        logic       sda;
    } cmd_t;

    // Front end to queue
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    // Queue to back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_rd_t;

endpackage

### rtl/i2cm_in_if.sv
interface i2cm_in_if;
    logic                valid;
    logic                ready;
    i2cm_pkg::in_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### rtl/i2cm_out_if.sv
interface i2cm_out_if;
    logic                valid;
    logic                ready;
    i2cm_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### rtl/i2cm_front.sv
module i2cm_front (
    i2cm_in_if.sink          req,
    input  logic             q_full,
    output i2cm_pkg::q_wr_t  q_wr
);

    // Accept while the queue has room
    assign req.ready = ~q_full;

    // Classify the request and pass on only the fields the back end uses
    always_comb
    begin
        q_wr.push                 = req.valid & ~q_full;
        q_wr.cmd.kind             = req.item.func ? i2cm_pkg::CMD_START
                                                  : i2cm_pkg::CMD_TICK;
        q_wr.cmd.is_read          = req.item.is_read;
        q_wr.cmd.device_address   = req.item.device_address;
        q_wr.cmd.register_address = req.item.register_address;
        q_wr.cmd.write_data       = req.item.write_data;
        q_wr.cmd.scl              = req.item.scl_in;
        q_wr.cmd.sda              = req.item.sda_in;
    end

endmodule

### rtl/i2cm_queue.sv
module i2cm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  i2cm_pkg::q_wr_t  q_wr,
    input  logic             pop,
    output logic             full,
    output i2cm_pkg::q_rd_t  q_rd
);

    localparam int CNT_W = $clog2(i2cm_pkg::QUEUE_DEPTH + 1);

    i2cm_pkg::cmd_t                slot_reg [i2cm_pkg::QUEUE_DEPTH];
    logic [i2cm_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [i2cm_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          do_pop;

    assign full       = (count_reg == CNT_W'(i2cm_pkg::QUEUE_DEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.cmd   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop & q_rd.valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == i2cm_pkg::QPTR_W'(i2cm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == i2cm_pkg::QPTR_W'(i2cm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({q_wr.push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            slot_reg[wr_ptr_reg] <= q_wr.cmd;
        end
    end

endmodule

### rtl/i2cm_back.sv
module i2cm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  i2cm_pkg::q_rd_t  q_rd,
    output logic             pop,
    i2cm_out_if.source       res
);

    i2cm_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       slot_reg, slot_next;
    logic [3:0]       bits_reg, bits_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       rx_byte_reg, rx_byte_next;
    logic             nack_reg, nack_next;
    logic             scl_low_reg, scl_low_next;
    logic             sda_low_reg, sda_low_next;
    logic             rd_reg, rd_next;
    logic [6:0]       dev_reg, dev_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       wdata_reg, wdata_next;
    logic             done;
    logic             out_valid_reg, out_valid_next;
    i2cm_pkg::out_item_t out_item_reg, out_item_next;

    // Byte to send for a given slot
    function automatic logic [7:0] pick_byte(input logic [2:0] slot, input logic rd,
                                             input logic [6:0] dev, input logic [7:0] addr,
                                             input logic [7:0] wdata);
        logic [7:0] b;
        if (slot == i2cm_pkg::SLOT_DEV_WR)
            b = {dev, 1'b0};
        else if (slot == i2cm_pkg::SLOT_REG)
            b = addr;
        else if (rd)
            b = {dev, 1'b1};
        else
            b = wdata;
        return b;
    endfunction

    // Take a request when the output slot is free or being emptied
    assign pop = q_rd.valid & (~out_valid_reg | res.ready);

    // Controller step
    always_comb
    begin
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        bits_next    = bits_reg;
        shift_next   = shift_reg;
        rx_byte_next = rx_byte_reg;
        nack_next    = nack_reg;
        scl_low_next = scl_low_reg;
        sda_low_next = sda_low_reg;
        rd_next      = rd_reg;
        dev_next     = dev_reg;
        addr_next    = addr_reg;
        wdata_next   = wdata_reg;
        done         = 1'b0;

        if (pop)
        begin
            if (q_rd.cmd.kind == i2cm_pkg::CMD_START)
            begin
                if (phase_reg == i2cm_pkg::PH_IDLE)
                begin
                    rd_next    = q_rd.cmd.is_read;
                    dev_next   = q_rd.cmd.device_address;
                    addr_next  = q_rd.cmd.register_address;
                    wdata_next = q_rd.cmd.write_data;
                    slot_next  = i2cm_pkg::SLOT_DEV_WR;
                    bits_next  = '0;
                    phase_next = i2cm_pkg::PH_ST_SDA;
                end
            end
            else
            begin
                case (phase_reg)
                    i2cm_pkg::PH_IDLE:
                    begin
                    end
                    i2cm_pkg::PH_ST_SDA:
                    begin
                        sda_low_next = 1'b0;
                        phase_next   = i2cm_pkg::PH_ST_SCL;
                    end
                    i2cm_pkg::PH_ST_SCL:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = i2cm_pkg::PH_ST_LOW;
                    end
                    i2cm_pkg::PH_ST_LOW:
                    begin
                        if (q_rd.cmd.scl)
                        begin
                            sda_low_next = 1'b1;
                            phase_next   = i2cm_pkg::PH_ST_CLK;
                        end
                    end
                    i2cm_pkg::PH_ST_CLK:
                    begin
                        scl_low_next = 1'b1;
                        shift_next   = pick_byte(slot_reg, rd_reg, dev_reg, addr_reg,
                                                 wdata_reg);
                        bits_next    = '0;
                        nack_next    = 1'b0;
                        phase_next   = i2cm_pkg::PH_TX_DATA;
                    end
                    i2cm_pkg::PH_TX_DATA:
                    begin
                        sda_low_next = ~shift_reg[7];
                        phase_next   = i2cm_pkg::PH_TX_CLK;
                    end
                    i2cm_pkg::PH_TX_CLK:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = i2cm_pkg::PH_TX_WAIT;
                    end
                    i2cm_pkg::PH_TX_WAIT:
                    begin
                        if (q_rd.cmd.scl)
                        begin
                            scl_low_next = 1'b1;
                            shift_next   = {shift_reg[6:0], 1'b0};
                            bits_next    = bits_reg + 1'b1;
                            phase_next   = (bits_next >= i2cm_pkg::BITS_PER_BYTE)
                                           ? i2cm_pkg::PH_ACK_REL : i2cm_pkg::PH_TX_DATA;
                        end
                    end
                    i2cm_pkg::PH_ACK_REL:
                    begin
                        sda_low_next = 1'b0;
                        phase_next   = i2cm_pkg::PH_ACK_CLK;
                    end
                    i2cm_pkg::PH_ACK_CLK:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = i2cm_pkg::PH_ACK_WAIT;
                    end
                    i2cm_pkg::PH_ACK_WAIT:
                    begin
                        if (q_rd.cmd.scl)
                        begin
                            nack_next    = q_rd.cmd.sda;
                            scl_low_next = 1'b1;
                            // next byte, repeated start, receive or stop
                            if (slot_reg == i2cm_pkg::SLOT_DEV_WR)
                            begin
                                slot_next  = i2cm_pkg::SLOT_REG;
                                shift_next = pick_byte(i2cm_pkg::SLOT_REG, rd_reg, dev_reg,
                                                       addr_reg, wdata_reg);
                                bits_next  = '0;
                                nack_next  = 1'b0;
                                phase_next = i2cm_pkg::PH_TX_DATA;
                            end
                            else if (slot_reg == i2cm_pkg::SLOT_REG)
                            begin
                                slot_next = i2cm_pkg::SLOT_THIRD;
                                if (rd_reg)
                                begin
                                    phase_next = i2cm_pkg::PH_ST_SCL;
                                end
                                else
                                begin
                                    shift_next = pick_byte(i2cm_pkg::SLOT_THIRD, rd_reg,
                                                           dev_reg, addr_reg, wdata_reg);
                                    bits_next  = '0;
                                    nack_next  = 1'b0;
                                    phase_next = i2cm_pkg::PH_TX_DATA;
                                end
                            end
                            else if (rd_reg)
                            begin
                                shift_next = '0;
                                bits_next  = '0;
                                phase_next = i2cm_pkg::PH_RX_CLK;
                            end
                            else
                            begin
                                phase_next = i2cm_pkg::PH_SP_SDA;
                            end
                        end
                    end
                    i2cm_pkg::PH_RX_CLK:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = i2cm_pkg::PH_RX_WAIT;
                    end
                    i2cm_pkg::PH_RX_WAIT:
                    begin
                        if (q_rd.cmd.scl)
                        begin
                            scl_low_next = 1'b1;
                            shift_next   = {shift_reg[6:0], q_rd.cmd.sda};
                            bits_next    = bits_reg + 1'b1;
                            if (bits_next >= i2cm_pkg::BITS_PER_BYTE)
                            begin
                                rx_byte_next = shift_next;
                                phase_next   = i2cm_pkg::PH_NK_CLK;
                            end
                            else
                            begin
                                phase_next = i2cm_pkg::PH_RX_CLK;
                            end
                        end
                    end
                    i2cm_pkg::PH_NK_CLK:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = i2cm_pkg::PH_NK_WAIT;
                    end
                    i2cm_pkg::PH_NK_WAIT:
                    begin
                        if (q_rd.cmd.scl)
                        begin
                            scl_low_next = 1'b1;
                            phase_next   = i2cm_pkg::PH_SP_SDA;
                        end
                    end
                    i2cm_pkg::PH_SP_SDA:
                    begin
                        sda_low_next = 1'b1;
                        phase_next   = i2cm_pkg::PH_SP_SCL;
                    end
                    i2cm_pkg::PH_SP_SCL:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = i2cm_pkg::PH_SP_WAIT;
                    end
                    i2cm_pkg::PH_SP_WAIT:
                    begin
                        if (q_rd.cmd.scl)
                        begin
                            sda_low_next = 1'b0;
                            done         = 1'b1;
                            phase_next   = i2cm_pkg::PH_IDLE;
                        end
                    end
                    default:
                    begin
                        scl_low_next = 1'b0;
                        sda_low_next = 1'b0;
                        phase_next   = i2cm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg & ~res.ready;
        out_item_next  = out_item_reg;
        if (pop)
        begin
            out_valid_next              = 1'b1;
            out_item_next.scl_drive_low = scl_low_next;
            out_item_next.sda_drive_low = sda_low_next;
            out_item_next.busy_res      = (phase_next != i2cm_pkg::PH_IDLE);
            out_item_next.done_res      = done;
            out_item_next.nack          = nack_next;
            out_item_next.read_data     = rx_byte_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            slot_reg      <= '0;
            bits_reg      <= '0;
            shift_reg     <= '0;
            rx_byte_reg   <= '0;
            nack_reg      <= 1'b0;
            scl_low_reg   <= 1'b0;
            sda_low_reg   <= 1'b0;
            rd_reg        <= 1'b0;
            dev_reg       <= '0;
            addr_reg      <= '0;
            wdata_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            bits_reg      <= bits_next;
            shift_reg     <= shift_next;
            rx_byte_reg   <= rx_byte_next;
            nack_reg      <= nack_next;
            scl_low_reg   <= scl_low_next;
            sda_low_reg   <= sda_low_next;
            rd_reg        <= rd_next;
            dev_reg       <= dev_next;
            addr_reg      <= addr_next;
            wdata_reg     <= wdata_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

### rtl/i2c_master_register_access.sv
// A request accepted into the queue is popped by the controller step, and its result is
// registered in the output register, where it is held until it is taken.
// Throughput: one request per cycle while results are taken; the controller step runs once per request
// popped from the two-entry queue, and the output register frees itself in the cycle it is taken.
// Reset (rst_n, asynchronous, active low): controller idle, both lines released,
// queue and output register empty.
module i2c_master_register_access (
    input  logic       clk,
    input  logic       rst_n,
    i2cm_in_if.sink    req,
    i2cm_out_if.source res
);

    i2cm_pkg::q_wr_t q_wr;
    i2cm_pkg::q_rd_t q_rd;
    logic            q_full;
    logic            q_pop;

    // Accept and classify
    i2cm_front u_front (
        .req    (req),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    // Decoupling queue
    i2cm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    // Line controller and result register
    i2cm_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_rd  (q_rd),
        .pop   (q_pop),
        .res   (res)
    );

endmodule
